// ===== hw/rtl/cstp_pkg.sv =====
// Shared widths, defaults and field layout for the exclusive-time profiler.
package cstp_pkg;

	localparam int FUNC_ID_W       = 6;
	localparam int TIME_W          = 32;
	localparam int CFG_W           = 7;
	localparam int TDATA_W         = 40;
	localparam int MAX_FUNCS_DEF   = 64;
	localparam int STACK_DEPTH_DEF = 64;
	localparam int FUNC_COUNT_RST  = 64;

	typedef logic [FUNC_ID_W-1:0] func_id_t;
	typedef logic [TIME_W-1:0]    time_val_t;

endpackage

// ===== hw/rtl/call_stack_exclusive_time_profiler.sv =====
// Exclusive-time profiler: call stack and totals table in synchronous memories.
// Each event is accepted in IDLE, then credited by a totals read-modify-write through
// the single totals read port in CREDIT; s_tready is high only in IDLE. Readout after
// a last event reads and zeroes all MAX_FUNCS entries, one per cycle unless the output
// stalls, and emits the first function_count of them, one per cycle while m_tready is
// high; m_tvalid first rises after CREDIT, the first sweep read and the output register.
// Reset: async, then clearing MAX_FUNCS entries, s_tready low; config writes taken throughout.
module call_stack_exclusive_time_profiler
	import cstp_pkg::*;
#(
	parameter int MAX_FUNCS   = MAX_FUNCS_DEF,
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// trace event input
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // [5:0] func_id, [37:6] timestamp, [39:38] zero
	input  logic               s_tuser,   // [0] is_start
	input  logic               s_tlast,   // last_event
	// readout output
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // [5:0] result_func, [37:6] exclusive_time, [39:38] zero
	output logic               m_tuser,   // [0] overflow_seen
	output logic               m_tlast,   // last_result
	// function_count register
	input  logic               cfg_we,
	input  logic [CFG_W-1:0]   cfg_wdata
);

	// totals address, sweep counter, stack address and stack fill widths
	localparam int FA = (MAX_FUNCS > 1) ? $clog2(MAX_FUNCS) : 1;
	localparam int KW = $clog2(MAX_FUNCS + 1);
	localparam int LW = (KW > CFG_W) ? KW : CFG_W;
	localparam int SA = $clog2(STACK_DEPTH);
	localparam int FW = $clog2(STACK_DEPTH + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_CREDIT = 2'd1;
	localparam logic [1:0] ST_SWEEP  = 2'd2;

	logic [1:0]       state_q;
	logic [CFG_W-1:0] func_count_q;

	// stack bookkeeping; top_q caches the id at stack[fill-1]
	logic [FW-1:0]    fill_q;
	func_id_t         top_q;
	time_val_t        mark_q;
	logic             ovf_q;

	// memories
	func_id_t         stk_mem [STACK_DEPTH];
	func_id_t         stk_rd;
	time_val_t        tot_mem [MAX_FUNCS];
	time_val_t        tot_rd;

	// event pipeline
	logic             credit_s1;
	logic             pop_s1;
	logic             last_s1;
	logic [FA-1:0]    top_s1;
	time_val_t        amount_s1;

	// readout sweep
	logic [KW-1:0]    k_q;
	logic [KW-1:0]    emit_lim_q;
	logic             rd_ovf_q;
	logic             hold_s1;
	logic [KW-1:0]    k_s1;
	logic             rlast_s1;
	logic             rovf_s1;

	// output register
	logic             out_valid_q;
	func_id_t         out_func_q;
	time_val_t        out_time_q;
	logic             out_ovf_q;
	logic             out_last_q;

	func_id_t         ev_id;
	time_val_t        ev_ts;
	logic             ev_start;
	logic             accept;
	logic             full;
	logic             empty;
	logic             do_push;
	logic             do_pop;
	logic             load;
	logic             issue;
	logic [LW-1:0]    cnt_ext;
	logic [KW-1:0]    cnt_clamp;

	logic             tot_re;
	logic [FA-1:0]    tot_ra;
	logic             tot_we;
	logic [FA-1:0]    tot_wa;
	time_val_t        tot_wd;

	assign ev_id    = s_tdata[FUNC_ID_W-1:0];
	assign ev_ts    = s_tdata[FUNC_ID_W +: TIME_W];
	assign ev_start = s_tuser;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign empty    = (fill_q == '0);
	assign full     = (fill_q == FW'(STACK_DEPTH));
	// empty stack pushes regardless of kind
	assign do_push  = accept && (empty || ev_start);
	assign do_pop   = accept && !empty && !ev_start;

	// output stage takes the held sweep data when it is free or draining
	assign load  = hold_s1 && (!out_valid_q || m_tready);
	assign issue = (state_q == ST_SWEEP) && (k_q != KW'(MAX_FUNCS)) && (!hold_s1 || load);

	// function_count clamped to 1 .. MAX_FUNCS
	assign cnt_ext = LW'(func_count_q);
	always_comb begin
		if (cnt_ext == '0) begin
			cnt_clamp = KW'(1);
		end else if (cnt_ext > LW'(MAX_FUNCS)) begin
			cnt_clamp = KW'(MAX_FUNCS);
		end else begin
			cnt_clamp = KW'(cnt_ext);
		end
	end

	// totals port control: credit read on accept, write-back in the credit cycle,
	// read-and-zero during the sweep
	always_comb begin
		tot_re = 1'b0;
		tot_ra = k_q[FA-1:0];
		tot_we = 1'b0;
		tot_wa = k_q[FA-1:0];
		tot_wd = '0;
		if (issue) begin
			tot_re = 1'b1;
			tot_we = 1'b1;
		end else if (accept) begin
			tot_re = !empty;
			tot_ra = FA'(top_q);
		end else if (state_q == ST_CREDIT) begin
			tot_we = credit_s1;
			tot_wa = top_s1;
			tot_wd = tot_rd + amount_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (tot_we) begin
			tot_mem[tot_wa] <= tot_wd;
		end
		if (tot_re) begin
			tot_rd <= tot_mem[tot_ra];
		end
	end

	// stack: push writes at fill, pop reads the entry that becomes the new top
	always_ff @(posedge clk) begin
		if (do_push && !full) begin
			stk_mem[fill_q[SA-1:0]] <= ev_id;
		end
		if (do_pop && (fill_q > FW'(1))) begin
			stk_rd <= stk_mem[SA'(fill_q - FW'(2))];
		end
	end

	// event pipeline payload
	always_ff @(posedge clk) begin
		if (accept) begin
			top_s1    <= FA'(top_q);
			amount_s1 <= ev_start ? (ev_ts - mark_q) : (ev_ts - mark_q + TIME_W'(1));
		end
	end

	// control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			func_count_q <= CFG_W'(FUNC_COUNT_RST);
			fill_q       <= '0;
			top_q        <= '0;
			mark_q       <= '0;
			ovf_q        <= 1'b0;
			credit_s1    <= 1'b0;
			pop_s1       <= 1'b0;
			last_s1      <= 1'b0;
			k_q          <= '0;
			emit_lim_q   <= '0;
			rd_ovf_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				func_count_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q   <= ST_CREDIT;
						credit_s1 <= !empty && (int'(top_q) < MAX_FUNCS);
						pop_s1    <= do_pop;
						last_s1   <= s_tlast;
						if (do_push) begin
							mark_q <= ev_ts;
							if (full) begin
								ovf_q <= 1'b1;
							end else begin
								fill_q <= fill_q + FW'(1);
								top_q  <= ev_id;
							end
						end else begin
							mark_q <= ev_ts + TIME_W'(1);
							fill_q <= fill_q - FW'(1);
						end
					end
				end
				ST_CREDIT: begin
					if (pop_s1) begin
						top_q <= stk_rd;
					end
					if (last_s1) begin
						// snapshot flag, clear stack and mark, start readout
						state_q    <= ST_SWEEP;
						k_q        <= '0;
						emit_lim_q <= cnt_clamp;
						rd_ovf_q   <= ovf_q;
						ovf_q      <= 1'b0;
						fill_q     <= '0;
						mark_q     <= '0;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SWEEP: begin
					if (issue) begin
						k_q <= k_q + KW'(1);
					end
					// read data register must be free before the next credit read
					if ((k_q == KW'(MAX_FUNCS)) && !hold_s1) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// sweep stage: tracks whether tot_rd holds a total to report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_s1 <= 1'b0;
		end else if (issue) begin
			hold_s1 <= (k_q < emit_lim_q);
		end else if (load) begin
			hold_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			k_s1     <= k_q;
			rlast_s1 <= (k_q + KW'(1) == emit_lim_q);
			rovf_s1  <= rd_ovf_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_func_q <= FUNC_ID_W'(k_s1);
			out_time_q <= tot_rd;
			out_ovf_q  <= rovf_s1;
			out_last_q <= rlast_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(TDATA_W - FUNC_ID_W - TIME_W){1'b0}}, out_time_q, out_func_q};
	assign m_tuser  = out_ovf_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== verif/cstp_checker.sv =====
// Monitor for the exclusive-time profiler: tracks events, predicts readout totals, compares.
module cstp_checker
	import cstp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,
	input  logic               s_tuser,
	input  logic               s_tlast,
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [TDATA_W-1:0] m_tdata,
	input  logic               m_tuser,
	input  logic               m_tlast,
	input  logic               cfg_we,
	input  logic [CFG_W-1:0]   cfg_wdata,
	output int                 mismatches,
	output int                 owed,
	output int                 totals_checked
);

	typedef struct {
		func_id_t  func;
		time_val_t total;
		bit        ovf;
		bit        closing;
	} total_rec_t;

	func_id_t         open_ids [STACK_DEPTH_DEF];
	int unsigned      open_depth;
	time_val_t        mark;
	time_val_t        excl [MAX_FUNCS_DEF];
	bit               push_dropped;
	logic [CFG_W-1:0] report_count;
	total_rec_t       owed_totals [$];

	// per-transaction scratch
	func_id_t         ev_id;
	time_val_t        ev_ts;
	int               n_report;
	total_rec_t       rec;
	func_id_t         got_func;
	time_val_t        got_total;

	function automatic void wipe_trace();
		for (int i = 0; i < MAX_FUNCS_DEF; i++)
			excl[i] = '0;
		open_depth   = 0;
		mark         = '0;
		push_dropped = 1'b0;
	endfunction

	function automatic void credit_top(time_val_t amount);
		func_id_t top_id;
		top_id = open_ids[open_depth - 1];
		if (top_id < MAX_FUNCS_DEF)
			excl[top_id] = excl[top_id] + amount;
	endfunction

	function automatic void push_call(func_id_t id);
		if (open_depth < STACK_DEPTH_DEF) begin
			open_ids[open_depth] = id;
			open_depth++;
		end else begin
			push_dropped = 1'b1;
		end
	endfunction

	function automatic void note_mismatch(string what);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $time, what);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_trace();
			report_count = CFG_W'(FUNC_COUNT_RST);
			owed_totals.delete();
			mismatches     = 0;
			totals_checked = 0;
		end else begin
			if (cfg_we)
				report_count = cfg_wdata;

			if (s_tvalid && s_tready) begin
				ev_id = s_tdata[FUNC_ID_W-1:0];
				ev_ts = s_tdata[FUNC_ID_W +: TIME_W];
				if (open_depth == 0) begin
					// empty stack pushes whatever the event kind
					push_call(ev_id);
					mark = ev_ts;
				end else if (s_tuser) begin
					credit_top(ev_ts - mark);
					push_call(ev_id);
					mark = ev_ts;
				end else begin
					credit_top(ev_ts - mark + 1);
					open_depth--;
					mark = ev_ts + 1;
				end
				if (s_tlast) begin
					n_report = report_count;
					if (n_report < 1)
						n_report = 1;
					if (n_report > MAX_FUNCS_DEF)
						n_report = MAX_FUNCS_DEF;
					for (int k = 0; k < n_report; k++) begin
						rec.func    = func_id_t'(k);
						rec.total   = excl[k];
						rec.ovf     = push_dropped;
						rec.closing = (k == n_report - 1);
						owed_totals.push_back(rec);
					end
					wipe_trace();
				end
			end

			if (m_tvalid && m_tready) begin
				got_func  = m_tdata[FUNC_ID_W-1:0];
				got_total = m_tdata[FUNC_ID_W +: TIME_W];
				if (owed_totals.size() == 0) begin
					note_mismatch($sformatf("readout transaction with nothing owed: func %0d total %0d",
						got_func, got_total));
				end else begin
					rec = owed_totals.pop_front();
					totals_checked++;
					if (got_func !== rec.func || got_total !== rec.total ||
						m_tuser !== rec.ovf || m_tlast !== rec.closing)
						note_mismatch($sformatf(
							"expected func %0d total %0d ovf %0b last %0b, got func %0d total %0d ovf %0b last %0b",
							rec.func, rec.total, rec.ovf, rec.closing,
							got_func, got_total, m_tuser, m_tlast));
				end
			end
		end
		owed = owed_totals.size();
	end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the exclusive-time profiler: stimulus, handshake pacing and verdict.
module tb;
	import cstp_pkg::*;

	// No transaction on either channel for this long means a hang. Long legal quiet
	// stretches are the settle pause before a count write and reset plus clearing pass.
	localparam int WATCHDOG_LIMIT = 1000;
	// Readout sweeps all 64 table entries even when fewer are reported, so give it
	// room to finish before touching function_count or ending the run.
	localparam int SETTLE_CYCLES  = 100;
	localparam int EVENT_BUDGET   = 270;
	localparam int PAD_W          = TDATA_W - TIME_W - FUNC_ID_W;

	typedef struct {
		func_id_t  id;
		bit        starting;
		time_val_t ts;
	} trace_ev_t;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata;   // [5:0] func_id, [37:6] timestamp, [39:38] zero
	logic               s_tuser;   // [0] is_start
	logic               s_tlast;   // last_event
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;   // [5:0] result_func, [37:6] exclusive_time, [39:38] zero
	logic               m_tuser;   // [0] overflow_seen
	logic               m_tlast;   // last_result
	logic               cfg_we;
	logic [CFG_W-1:0]   cfg_wdata;

	int mismatches;
	int owed;
	int totals_checked;

	trace_ev_t trace_evs [$];
	time_val_t now_ts;
	bit        s_burst;
	bit        m_burst;
	bit        deep_done;
	int        events_sent;
	int        traces_run;
	int        count_writes;
	int        plan_idx;
	int        quiet_cycles;

	// function_count sweep: minimum, zero (clamps up), max code (clamps down),
	// exact table size, one past it, then 2, then random
	logic [CFG_W-1:0] count_plan [6] = '{7'd1, 7'd0, 7'd127, 7'd64, 7'd65, 7'd2};

	call_stack_exclusive_time_profiler u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	cstp_checker u_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.s_tlast        (s_tlast),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.mismatches     (mismatches),
		.owed           (owed),
		.totals_checked (totals_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: counts cycles with no transaction on either channel.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d totals still owed",
				quiet_cycles, owed);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Readout sink: per result, hold tready low for a drawn number of cycles, then
	// wait for the transaction. Burst mode flips now and then for back-to-back stretches.
	initial begin
		int gap;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 15) == 0)
				m_burst = !m_burst;
			gap = m_burst ? 0 : $urandom_range(0, 17);
			if (gap > 0) begin
				m_tready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			@(negedge clk);
		end
	end

	function automatic void add_ev(func_id_t id, bit starting, time_val_t ts);
		trace_evs.push_back('{id, starting, ts});
	endfunction

	// Mostly small forward steps; sometimes no step (end then start at the same tick
	// credits -1, wrapping) or a huge jump that wraps the 32-bit clock.
	function automatic time_val_t advance();
		case ($urandom_range(0, 9))
			0:       now_ts = now_ts;
			1:       now_ts = now_ts + $urandom();
			default: now_ts = now_ts + $urandom_range(1, 20);
		endcase
		return now_ts;
	endfunction

	function automatic func_id_t any_id();
		return func_id_t'($urandom_range(0, 63));
	endfunction

	// One event transaction on the trace channel; idle cycles carry junk data.
	task automatic send_event(trace_ev_t ev, bit closing);
		int gap;
		gap = s_burst ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			s_tdata  = TDATA_W'({$urandom(), $urandom()});
			s_tuser  = 1'($urandom_range(0, 1));
			s_tlast  = 1'($urandom_range(0, 1));
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {{PAD_W{1'b0}}, ev.ts, ev.id};
		s_tuser  = ev.starting;
		s_tlast  = closing;
		do @(posedge clk); while (s_tready !== 1'b1);
		@(negedge clk);
		s_tvalid = 1'b0;
		events_sent++;
	endtask

	// Sends the queued trace, flagging its final event to trigger the readout.
	task automatic play_trace();
		for (int i = 0; i < trace_evs.size(); i++)
			send_event(trace_evs[i], i == trace_evs.size() - 1);
		trace_evs.delete();
		traces_run++;
	endtask

	task automatic wait_drained();
		while (owed != 0)
			@(negedge clk);
	endtask

	// Count writes only with the block idle: all totals out and the sweep finished.
	task automatic set_report_count(logic [CFG_W-1:0] value);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we    = 1'b0;
		count_writes++;
	endtask

	// Well-formed call tree with random nesting, sometimes recursing into an open id.
	// Occasionally the tree is cut off with calls still open at the readout.
	task automatic build_nested();
		func_id_t open_q [$];
		func_id_t id;
		int       n;
		bit       cut_short;
		n = $urandom_range(2, 16);
		cut_short = ($urandom_range(0, 5) == 0);
		if ($urandom_range(0, 3) == 0)
			now_ts = $urandom();
		for (int i = 0; i < n; i++) begin
			if (open_q.size() == 0 || (open_q.size() < 12 && $urandom_range(0, 1) == 1)) begin
				if (open_q.size() > 0 && $urandom_range(0, 3) == 0)
					id = open_q[$urandom_range(0, open_q.size() - 1)];
				else
					id = any_id();
				add_ev(id, 1'b1, advance());
				open_q.push_back(id);
			end else begin
				add_ev(open_q.pop_back(), 1'b0, advance());
			end
		end
		if (!cut_short)
			while (open_q.size() > 0)
				add_ev(open_q.pop_back(), 1'b0, advance());
	endtask

	// Nests past the stack depth so pushes get dropped and the overflow flag sticks.
	task automatic build_deep();
		repeat ($urandom_range(65, 70))
			add_ev(any_id(), 1'b1, advance());
		repeat ($urandom_range(0, 4))
			add_ev(any_id(), 1'b0, advance());
		deep_done = 1'b1;
	endtask

	// Garbage traces: random kinds, ids and timestamps anywhere in the 32-bit range.
	task automatic build_noise();
		repeat ($urandom_range(1, 8))
			add_ev(any_id(), 1'($urandom_range(0, 1)), time_val_t'($urandom()));
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		s_tlast   = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		now_ts    = '0;
		s_burst   = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// --- directed traces, function_count at its reset value ---
		// textbook case: 0 runs 0..1 and 6, 1 runs 2..5
		add_ev(6'd0, 1'b1, 32'd0);
		add_ev(6'd1, 1'b1, 32'd2);
		add_ev(6'd1, 1'b0, 32'd5);
		add_ev(6'd0, 1'b0, 32'd6);
		play_trace();
		// top id and top timestamp; end at all-ones wraps the mark to zero
		add_ev(6'd63, 1'b1, 32'hFFFF_FFF0);
		add_ev(6'd0,  1'b1, 32'hFFFF_FFFF);
		add_ev(6'd0,  1'b0, 32'hFFFF_FFFF);
		add_ev(6'd63, 1'b0, 32'h0000_0004);
		play_trace();
		// lone end on an empty stack is pushed, then read out right away
		add_ev(6'd42, 1'b0, 32'd100);
		play_trace();
		// timestamps running backwards: differences wrap
		add_ev(6'd5, 1'b1, 32'd1000);
		add_ev(6'd6, 1'b1, 32'd500);
		add_ev(6'd6, 1'b0, 32'd400);
		add_ev(6'd5, 1'b0, 32'd300);
		play_trace();
		// readout with calls still open, last flag on a start
		add_ev(6'd21, 1'b1, 32'hFFFF_FFFF);
		add_ev(6'd42, 1'b1, 32'h5555_5555);
		play_trace();
		// recursion into the same id
		add_ev(6'd7, 1'b1, 32'd10);
		add_ev(6'd7, 1'b1, 32'd12);
		add_ev(6'd7, 1'b0, 32'd15);
		add_ev(6'd7, 1'b0, 32'd20);
		play_trace();

		// --- random traces; function_count changes every other trace ---
		while (events_sent < EVENT_BUDGET) begin
			if (traces_run % 2 == 0) begin
				set_report_count(plan_idx < 6 ? count_plan[plan_idx]
				                              : CFG_W'($urandom_range(0, 127)));
				plan_idx++;
			end
			s_burst = ($urandom_range(0, 3) == 0);
			if (!deep_done && traces_run >= 8)
				build_deep();
			else
				case ($urandom_range(0, 11))
					0, 1:    build_noise();
					2:       build_deep();
					default: build_nested();
				endcase
			play_trace();
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("%0d trace events in %0d traces, %0d totals compared, %0d count writes",
			events_sent, traces_run, totals_checked, count_writes);
		$display("covered nesting, recursion, wrapped and backward time, stack overflow, clamped counts");
		if (mismatches == 0 && owed == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
